### design/tlrcc_pkg.sv
// Package for the two-level row cache controller.
// Holds shared widths, codes, tag and divider handshake types; no dependencies.

package tlrcc_pkg;

   localparam int ROW_W    = 10;
   localparam int LINE_W   = 11;
   localparam int CSR_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam int SLOT_OUT_W = 6;
   localparam int COUNT_W  = 32;
   localparam int DIV_CNT_W = $clog2(ROW_W);

   typedef enum logic [1:0] {
      OUT_REJECT  = 2'd0,
      OUT_L1_HIT  = 2'd1,
      OUT_L2_HIT  = 2'd2,
      OUT_MISS    = 2'd3
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_LINES  = 2'd0,
      CSR_SECOND_LINES = 2'd1,
      CSR_HIGHEST_NODE = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD1,
      ST_RD1,
      ST_CHK1,
      ST_MOD2,
      ST_RD2,
      ST_CHK2,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
   } tag_type;

   typedef struct packed {
      logic              start;
      logic [ROW_W-1:0]  dividend;
      logic [LINE_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [LINE_W-1:0] remainder;
   } div_rsp_type;

endpackage

### design/tlrcc_mod_unit.sv
// Shared iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on tlrcc_pkg.

module tlrcc_mod_unit import tlrcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]     sh_ff, sh_in;
   logic [LINE_W-1:0]    rem_ff, rem_in;
   logic [LINE_W-1:0]    dvs_ff, dvs_in;
   logic [LINE_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, sh_ff[ROW_W-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         sh_in = {sh_ff[ROW_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = LINE_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[LINE_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(ROW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

### design/two_level_row_cache_controller_unit.sv
// Two-level direct-mapped row cache tag controller, top level.
// Depends on tlrcc_pkg and tlrcc_mod_unit.
//
// One request is handled at a time; req_stall is high from the transfer until the result
// is taken. A rejected row gives its result in the cycle after the transfer. Otherwise each
// slot is found by the shared remainder unit, followed by a registered tag read and a
// check; level two is looked up only when level one does not decide the outcome.
// After reset the tag memories are cleared, during which no request is taken; the
// configuration port (csr_ready always high) takes writes at any time.

module two_level_row_cache_controller_unit import tlrcc_pkg::*; #(
   parameter int FIRST_DEPTH  = 64,
   parameter int SECOND_DEPTH = 64,
   parameter int MAX_ROWS     = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ROW_W-1:0]      req_row_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_outcome,
   output logic [SLOT_OUT_W-1:0] rsp_first_slot,
   output logic [SLOT_OUT_W-1:0] rsp_second_slot,
   output logic [COUNT_W-1:0]    rsp_first_hit_total,
   output logic [COUNT_W-1:0]    rsp_second_hit_total,
   output logic [COUNT_W-1:0]    rsp_miss_total,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int S1W  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
   localparam int S2W  = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
   localparam int MAXD = (FIRST_DEPTH > SECOND_DEPTH) ? FIRST_DEPTH : SECOND_DEPTH;
   localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;

   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [LINE_W-1:0]    l2n_ff, l2n_in;
   logic [S1W-1:0]       s1_ff, s1_in;
   logic [S2W-1:0]       s2_ff, s2_in;
   outcome_type          outcome_ff, outcome_in;
   logic [COUNT_W-1:0]   first_hits_ff, first_hits_in;
   logic [COUNT_W-1:0]   second_hits_ff, second_hits_in;
   logic [COUNT_W-1:0]   misses_ff, misses_in;
   logic [CW-1:0]        clr_ff, clr_in;
   logic [CSR_W-1:0]     first_lines_ff, second_lines_ff;
   logic [ROW_W-1:0]     highest_ff;

   tag_type              tag1_mem [FIRST_DEPTH];
   tag_type              tag2_mem [SECOND_DEPTH];
   tag_type              tag1_rd_ff, tag2_rd_ff;
   logic                 tag1_we, tag2_we;
   logic [S1W-1:0]       tag1_wa;
   logic [S2W-1:0]       tag2_wa;
   tag_type              tag1_wd, tag2_wd;

   logic [LINE_W-1:0]    l1n, l2n, first_ext, second_ext;
   logic                 reject;
   div_cmd_type          div_cmd;
   div_rsp_type          div_rsp;

   tlrcc_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_lines_ff  <= CSR_W'(64);
         second_lines_ff <= CSR_W'(64);
         highest_ff      <= ROW_W'(1023);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_LINES:  first_lines_ff  <= csr_wdata[CSR_W-1:0];
            CSR_SECOND_LINES: second_lines_ff <= csr_wdata[CSR_W-1:0];
            CSR_HIGHEST_NODE: highest_ff      <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   assign first_ext  = LINE_W'(first_lines_ff);
   assign second_ext = LINE_W'(second_lines_ff);
   assign l1n = (first_ext > LINE_W'(FIRST_DEPTH)) ? LINE_W'(FIRST_DEPTH) : first_ext;
   assign l2n = (second_ext > LINE_W'(SECOND_DEPTH)) ? LINE_W'(SECOND_DEPTH) : second_ext;
   assign reject = (req_row_index > highest_ff) ||
                   (32'(req_row_index) >= 32'(MAX_ROWS)) || (l1n == '0);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         first_hits_ff  <= '0;
         second_hits_ff <= '0;
         misses_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         first_hits_ff  <= first_hits_in;
         second_hits_ff <= second_hits_in;
         misses_ff      <= misses_in;
      end
      row_ff     <= row_in;
      l2n_ff     <= l2n_in;
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      outcome_ff <= outcome_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      row_in         = row_ff;
      l2n_in         = l2n_ff;
      s1_in          = s1_ff;
      s2_in          = s2_ff;
      outcome_in     = outcome_ff;
      first_hits_in  = first_hits_ff;
      second_hits_in = second_hits_ff;
      misses_in      = misses_ff;
      div_cmd        = '0;
      tag1_we        = 1'b0;
      tag2_we        = 1'b0;
      tag1_wa        = s1_ff;
      tag2_wa        = s2_ff;
      tag1_wd        = '{valid: 1'b1, row: row_ff};
      tag2_wd        = '{valid: 1'b1, row: row_ff};

      case (state_ff)
         ST_CLEAR: begin
            tag1_we = 32'(clr_ff) < FIRST_DEPTH;
            tag2_we = 32'(clr_ff) < SECOND_DEPTH;
            tag1_wa = clr_ff[S1W-1:0];
            tag2_wa = clr_ff[S2W-1:0];
            tag1_wd = '0;
            tag2_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == MAXD - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               row_in = req_row_index;
               l2n_in = l2n;
               s1_in  = '0;
               s2_in  = '0;
               if (reject) begin
                  outcome_in = OUT_REJECT;
                  state_in   = ST_RESP;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = req_row_index;
                  div_cmd.divisor  = l1n;
                  state_in         = ST_MOD1;
               end
            end
         end
         ST_MOD1: begin
            if (div_rsp.done) begin
               s1_in    = div_rsp.remainder[S1W-1:0];
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            state_in = ST_CHK1;
         end
         ST_CHK1: begin
            if (tag1_rd_ff.valid && tag1_rd_ff.row == row_ff) begin
               first_hits_in = first_hits_ff + 1'b1;
               outcome_in    = OUT_L1_HIT;
               state_in      = ST_RESP;
            end else if (l2n_ff != '0) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = row_ff;
               div_cmd.divisor  = l2n_ff;
               state_in         = ST_MOD2;
            end else begin
               tag1_we    = 1'b1;
               misses_in  = misses_ff + 1'b1;
               outcome_in = OUT_MISS;
               state_in   = ST_RESP;
            end
         end
         ST_MOD2: begin
            if (div_rsp.done) begin
               s2_in    = div_rsp.remainder[S2W-1:0];
               state_in = ST_RD2;
            end
         end
         ST_RD2: begin
            state_in = ST_CHK2;
         end
         ST_CHK2: begin
            tag1_we = 1'b1;
            if (tag2_rd_ff.valid && tag2_rd_ff.row == row_ff) begin
               second_hits_in = second_hits_ff + 1'b1;
               outcome_in     = OUT_L2_HIT;
            end else begin
               tag2_we    = 1'b1;
               misses_in  = misses_ff + 1'b1;
               outcome_in = OUT_MISS;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // tag memories
   always_ff @(posedge clock) begin
      if (tag1_we) begin
         tag1_mem[tag1_wa] <= tag1_wd;
      end
      tag1_rd_ff <= tag1_mem[s1_ff];
   end

   always_ff @(posedge clock) begin
      if (tag2_we) begin
         tag2_mem[tag2_wa] <= tag2_wd;
      end
      tag2_rd_ff <= tag2_mem[s2_ff];
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_RESP);
   assign rsp_outcome          = outcome_ff;
   assign rsp_first_slot       = SLOT_OUT_W'(s1_ff);
   assign rsp_second_slot      = SLOT_OUT_W'(s2_ff);
   assign rsp_first_hit_total  = first_hits_ff;
   assign rsp_second_hit_total = second_hits_ff;
   assign rsp_miss_total       = misses_ff;

   a_reject_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_REJECT |-> rsp_first_slot == '0 && rsp_second_slot == '0)
      else $error("rejected result carries a non-zero slot");

   a_l1_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_outcome == OUT_L1_HIT |->
         first_hits_ff == $past(first_hits_ff) + 32'd1)
      else $error("level one hit not counted once");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_MOD1 || state_ff == ST_MOD2)
      else $error("remainder unit finished outside a lookup");

endmodule
